FILE: hdl/ejacc_pkg.sv
// Package: widths, select codes and register indexes of the encoder jog accumulator.
`default_nettype none

package ejacc_pkg;

    // Field widths
    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 32;
    localparam int SEL_W    = 3;
    localparam int AXIS_W   = 2;
    localparam int SCALE_W  = 2;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // Four pulses per detent click, so the divide is a shift by two
    localparam int CLICK_SHIFT = 2;
    localparam int CLICKS_W    = COUNT_W - CLICK_SHIFT;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_GAP_RST = CFG_W'(20000);
    localparam logic [CFG_W-1:0] DIEOUT_RST  = CFG_W'(200000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIEOUT  = CFG_IDX_W'(1);

    // Button select codes
    localparam logic [SEL_W-1:0] SEL_NONE     = 3'd0;
    localparam logic [SEL_W-1:0] SEL_SCALE_1  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_SCALE_01 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_SCALE_001 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_AXIS_X   = 3'd4;
    localparam logic [SEL_W-1:0] SEL_AXIS_Y   = 3'd5;
    localparam logic [SEL_W-1:0] SEL_AXIS_Z   = 3'd6;

    // Axis and scale codes on the result
    localparam logic [AXIS_W-1:0]  AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0]  AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0]  AXIS_Z    = 2'd2;
    localparam logic [SCALE_W-1:0] SCALE_1   = 2'd0;
    localparam logic [SCALE_W-1:0] SCALE_01  = 2'd1;
    localparam logic [SCALE_W-1:0] SCALE_001 = 2'd2;

    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CLICKS_W-1:0] t_clicks;

endpackage

`default_nettype wire

FILE: hdl/ejacc_if.sv
// Interfaces: poll request, move request and register write channels.
`default_nettype none

interface ejacc_in_if import ejacc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        time_us;
    logic signed [COUNT_W-1:0] encoder_count;
    logic [SEL_W-1:0]         select_code;

    modport source (output valid, time_us, encoder_count, select_code, input ready);
    modport sink   (input valid, time_us, encoder_count, select_code, output ready);
endinterface

interface ejacc_out_if import ejacc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [AXIS_W-1:0]          axis;
    logic [SCALE_W-1:0]         scale;
    logic signed [CLICKS_W-1:0] clicks;

    modport source (output valid, axis, scale, clicks, input ready);
    modport sink   (input valid, axis, scale, clicks, output ready);
endinterface

interface ejacc_cfg_if import ejacc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/encoder_jog_accumulator_core.sv
// Top level: jog wheel pulse accumulator turning encoder polls into move requests.
//
//  Channel  Dir   Handshake      Payload
//  i_in     in    valid/ready    time_us[47:0], encoder_count[31:0], select_code[2:0]
//  o_out    out   valid/ready    axis[1:0], scale[1:0], clicks[29:0]
//  i_cfg    in    valid/ready    index[1:0], data[23:0] (0 min gap, 1 die-out)
//
//  One poll per cycle unless o_out stalls; a poll goes through the poll register, then the result register.
//  The poll register computes the count delta; the result stage does select,
//  accumulate, move decision and die-out combinationally: a 32-bit add followed by the
//  30-bit rounding increment, beside the 48-bit time compares.
//  A waiting move request stalls the poll register; once that holds a poll, i_in stalls.
//  Reset (i_rst_n low, synchronous) clears all state but the payload registers; no clearing pass follows.
//  Register writes are always taken (ready held high).
`default_nettype none

module encoder_jog_accumulator_core import ejacc_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ejacc_in_if.sink    i_in,
    ejacc_out_if.source o_out,
    ejacc_cfg_if.sink   i_cfg
);

    // Configuration registers
    logic [CFG_W-1:0] r_min_gap;
    logic [CFG_W-1:0] r_dieout;

    // Poll register
    logic                r_in_vld;
    t_time               r_time;
    t_count              r_delta;
    logic [SEL_W-1:0]    r_sel;
    t_count              r_prev_count;
    logic                r_have_prev;

    // Accumulator state
    t_count              r_acc;
    t_time               r_last_move;
    t_time               r_last_motion;
    logic [AXIS_W-1:0]   r_axis;
    logic [SCALE_W-1:0]  r_scale;

    // Result register
    logic                r_out_vld;
    logic [AXIS_W-1:0]   r_out_axis;
    logic [SCALE_W-1:0]  r_out_scale;
    t_clicks             r_out_clicks;

    logic                adv;
    logic                in_acc;
    logic [AXIS_W-1:0]   n_axis;
    logic [SCALE_W-1:0]  n_scale;
    t_count              acc_sum;
    t_time               move_age;
    t_time               motion_age;
    logic                gap_ok;
    logic                idle_long;
    logic                small_mag;
    logic                fire;
    logic                rem_nz;
    t_clicks             quot;
    t_count              rest;
    t_count              n_acc;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign adv         = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || adv;
    assign in_acc      = i_in.valid && i_in.ready;

    // Register writes; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap <= MIN_GAP_RST;
            r_dieout  <= DIEOUT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_MIN_GAP) begin
                r_min_gap <= i_cfg.data;
            end else if (i_cfg.index == REG_DIEOUT) begin
                r_dieout <= i_cfg.data;
            end
        end
    end

    // Capture the poll and its count delta; the first poll has zero delta
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_have_prev  <= 1'b0;
            r_prev_count <= '0;
        end else if (in_acc) begin
            r_in_vld     <= 1'b1;
            r_have_prev  <= 1'b1;
            r_prev_count <= i_in.encoder_count;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time  <= i_in.time_us;
            r_sel   <= i_in.select_code;
            r_delta <= r_have_prev ? (i_in.encoder_count - r_prev_count) : '0;
        end
    end

    // Apply the select code before the move decision
    always_comb begin
        n_axis  = r_axis;
        n_scale = r_scale;
        case (r_sel)
            SEL_SCALE_1:   n_scale = SCALE_1;
            SEL_SCALE_01:  n_scale = SCALE_01;
            SEL_SCALE_001: n_scale = SCALE_001;
            SEL_AXIS_X:    n_axis  = AXIS_X;
            SEL_AXIS_Y:    n_axis  = AXIS_Y;
            SEL_AXIS_Z:    n_axis  = AXIS_Z;
            default: begin
                n_axis  = r_axis;
                n_scale = r_scale;
            end
        endcase
    end

    // Accumulate, decide the move and check for die-out
    always_comb begin
        acc_sum    = r_acc + r_delta;
        move_age   = r_time - r_last_move;
        motion_age = r_time - r_last_motion;
        gap_ok     = move_age > TIME_W'(r_min_gap);
        idle_long  = (r_delta == '0) && (motion_age > TIME_W'(r_dieout));

        // Magnitude below one click: high bits all zero, or all ones with a nonzero tail
        rem_nz    = acc_sum[CLICK_SHIFT-1:0] != '0;
        small_mag = (acc_sum[COUNT_W-1:CLICK_SHIFT] == '0)
                 || ((acc_sum[COUNT_W-1:CLICK_SHIFT] == '1) && rem_nz);
        fire      = gap_ok && !small_mag;

        // Truncate toward zero: round a negative value with a remainder up by one
        quot = acc_sum[COUNT_W-1:CLICK_SHIFT]
             + CLICKS_W'(acc_sum[COUNT_W-1] && rem_nz);
        if (!rem_nz) begin
            rest = '0;
        end else if (acc_sum[COUNT_W-1]) begin
            rest = {{CLICKS_W{1'b1}}, acc_sum[CLICK_SHIFT-1:0]};
        end else begin
            rest = {{CLICKS_W{1'b0}}, acc_sum[CLICK_SHIFT-1:0]};
        end

        if (idle_long) begin
            n_acc = '0;
        end else if (fire) begin
            n_acc = rest;
        end else begin
            n_acc = acc_sum;
        end
    end

    // Advance the accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_last_move   <= '0;
            r_last_motion <= '0;
            r_axis        <= AXIS_X;
            r_scale       <= SCALE_1;
        end else if (adv) begin
            r_acc   <= n_acc;
            r_axis  <= n_axis;
            r_scale <= n_scale;
            if (fire) begin
                r_last_move <= r_time;
            end
            if (r_delta != '0) begin
                r_last_motion <= r_time;
            end
        end
    end

    // Hold the move request until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= fire;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && fire) begin
            r_out_axis   <= n_axis;
            r_out_scale  <= n_scale;
            r_out_clicks <= quot;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.axis   = r_out_axis;
    assign o_out.scale  = r_out_scale;
    assign o_out.clicks = r_out_clicks;

endmodule

`default_nettype wire

FILE: hdl/ejacc_chk.sv
// Checker: port-level assertions for the jog accumulator, bound to the top level.
`default_nettype none

module ejacc_chk import ejacc_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [AXIS_W-1:0]   i_out_axis,
    input wire [SCALE_W-1:0]  i_out_scale,
    input wire [CLICKS_W-1:0] i_out_clicks,
    input wire                i_cfg_ready
);

    // A stalled move request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_axis)
            && $stable(i_out_scale) && $stable(i_out_clicks))
        else $error("move request changed while stalled");

    // A move always carries at least one click
    a_clicks_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_clicks != '0)
        else $error("move request with zero clicks");

    // Polls are taken whenever no move request waits
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("poll refused with empty result register");

    // Reset leaves no move request behind
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("move request valid after reset");

    // Register writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write refused");

endmodule

bind encoder_jog_accumulator_core ejacc_chk u_ejacc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_axis   (o_out.axis),
    .i_out_scale  (o_out.scale),
    .i_out_clicks (o_out.clicks),
    .i_cfg_ready  (i_cfg.ready)
);

`default_nettype wire
